// File: hw/rtl/skrc_pkg.sv
// shared types and constants for the size keyed region recycle cache
// no dependencies; imported by the interfaces and every module but skrc_ram
`timescale 1ns / 1ps

package skrc_pkg;

	localparam int REGION_W    = 48;
	localparam int SIZE_W      = 48;
	localparam int OP_W        = 2;
	localparam int COUNT_OUT_W = 4;

	localparam logic [OP_W-1:0] OP_TAKE  = 2'd0;
	localparam logic [OP_W-1:0] OP_PUT   = 2'd1;
	localparam logic [OP_W-1:0] OP_DRAIN = 2'd2;

	typedef struct packed {
		logic [REGION_W-1:0] region;
		logic [SIZE_W-1:0]   size;
	} entry_t;

	typedef struct packed {
		logic                   found;
		logic [REGION_W-1:0]    region;
		logic [SIZE_W-1:0]      size;
		logic                   last;
		logic [COUNT_OUT_W-1:0] count;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MOVE_RD,
		ST_MOVE_WR,
		ST_SHIFT,
		ST_PUT_WR,
		ST_DRAIN,
		ST_RESULT
	} state_t;

endpackage

// File: hw/rtl/skrc_req_if.sv
// request channel: valid/ready handshake with op, region and size
// depends on skrc_pkg
`timescale 1ns / 1ps

interface skrc_req_if;
	import skrc_pkg::*;

	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     op;
	logic [REGION_W-1:0] req_region;
	logic [SIZE_W-1:0]   req_size;

	modport source (output valid, op, req_region, req_size, input ready);
	modport sink   (input valid, op, req_region, req_size, output ready);
endinterface

// File: hw/rtl/skrc_res_if.sv
// result channel: valid/ready handshake with the result fields
// depends on skrc_pkg
`timescale 1ns / 1ps

interface skrc_res_if;
	import skrc_pkg::*;

	logic                   valid;
	logic                   ready;
	logic                   found;
	logic [REGION_W-1:0]    out_region;
	logic [SIZE_W-1:0]      out_size;
	logic                   last;
	logic [COUNT_OUT_W-1:0] count_after;

	modport source (output valid, found, out_region, out_size, last, count_after,
		input ready);
	modport sink   (input valid, found, out_region, out_size, last, count_after,
		output ready);
endinterface

// File: hw/rtl/skrc_ram.sv
// generic simple dual port ram: one write port, one read port, registered read
// no dependencies
`timescale 1ns / 1ps

module skrc_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

// File: hw/rtl/skrc_ctrl.sv
// sequencer for take, put and drain: reads, modifies and writes the entry ram
// depends on skrc_pkg and skrc_req_if
`timescale 1ns / 1ps

module skrc_ctrl #(
	parameter int CAPACITY = 8,
	parameter int AW = 3
) (
	input  logic             clk,
	input  logic             arst_n,
	skrc_req_if.sink         req,
	input  logic             load_ok,
	output logic             res_load,
	output skrc_pkg::res_t   res,
	output logic             rd_en,
	output logic [AW-1:0]    rd_addr,
	input  skrc_pkg::entry_t rd_data,
	output logic             wr_en,
	output logic [AW-1:0]    wr_addr,
	output skrc_pkg::entry_t wr_data
);
	import skrc_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	state_t              state_q, state_d;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       iss_q;
	logic                rd_valid_s1;
	logic [AW-1:0]       rd_idx_s1;
	logic [AW-1:0]       hole_q;
	entry_t              ent_q;
	logic                rfound_q;
	logic [REGION_W-1:0] rregion_q;
	logic [SIZE_W-1:0]   rsize_q;

	logic          full;
	logic [CW-1:0] last_idx;
	logic          hit;
	logic          rd_last;
	logic          drain_last;

	function automatic logic [COUNT_OUT_W-1:0] cnt4(input logic [CW-1:0] c);
		logic [CW+COUNT_OUT_W-1:0] e;
		e = {{COUNT_OUT_W{1'b0}}, c};
		return e[COUNT_OUT_W-1:0];
	endfunction

	assign full       = (count_q == CW'(CAPACITY));
	assign last_idx   = CW'(count_q - 1'b1);
	assign hit        = rd_valid_s1 && (rd_data.size == ent_q.size);
	assign rd_last    = rd_valid_s1 && (CW'(rd_idx_s1) == last_idx);
	assign drain_last = (iss_q == last_idx);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					case (req.op)
						OP_TAKE:  state_d = (count_q == '0) ? ST_RESULT : ST_SCAN;
						OP_PUT:   state_d = full ? ST_SHIFT : ST_RESULT;
						OP_DRAIN: state_d = (count_q == '0) ? ST_RESULT : ST_DRAIN;
						default:  state_d = ST_RESULT;
					endcase
				end
			end
			ST_SCAN: begin
				if (hit) begin
					state_d = (CW'(rd_idx_s1) < last_idx) ? ST_MOVE_RD : ST_RESULT;
				end else if (rd_last) begin
					state_d = ST_RESULT;
				end
			end
			ST_MOVE_RD: state_d = ST_MOVE_WR;
			ST_MOVE_WR: state_d = ST_RESULT;
			ST_SHIFT: begin
				if (rd_last) begin
					state_d = ST_PUT_WR;
				end
			end
			ST_PUT_WR: state_d = ST_RESULT;
			ST_DRAIN: begin
				if (load_ok && drain_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_RESULT: begin
				if (load_ok) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req.ready = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = '0;
		wr_en     = 1'b0;
		wr_addr   = '0;
		wr_data   = ent_q;
		res_load  = 1'b0;
		res       = '0;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				wr_data   = '{region: req.req_region, size: req.req_size};
				wr_addr   = AW'(count_q);
				if (req.valid && (req.op == OP_PUT) && !full) begin
					wr_en = 1'b1;
				end
				if (req.valid && (req.op == OP_DRAIN) && (count_q != '0)) begin
					rd_en = 1'b1;
				end
			end
			ST_SCAN: begin
				rd_en   = (iss_q < count_q) && !hit;
				rd_addr = AW'(iss_q);
			end
			ST_MOVE_RD: begin
				// count already dropped: this is the old last entry
				rd_en   = 1'b1;
				rd_addr = AW'(count_q);
			end
			ST_MOVE_WR: begin
				wr_en   = 1'b1;
				wr_addr = hole_q;
				wr_data = rd_data;
			end
			ST_SHIFT: begin
				rd_en   = (iss_q < count_q);
				rd_addr = AW'(iss_q);
				wr_data = rd_data;
				wr_addr = AW'(rd_idx_s1 - 1'b1);
				wr_en   = rd_valid_s1 && (rd_idx_s1 != '0);
			end
			ST_PUT_WR: begin
				wr_en   = 1'b1;
				wr_addr = AW'(last_idx);
			end
			ST_DRAIN: begin
				res_load   = load_ok;
				res.found  = 1'b1;
				res.region = rd_data.region;
				res.size   = rd_data.size;
				res.last   = drain_last;
				res.count  = '0;
				rd_en      = load_ok && !drain_last;
				rd_addr    = AW'(iss_q + 1'b1);
			end
			ST_RESULT: begin
				res_load   = load_ok;
				res.found  = rfound_q;
				res.region = rregion_q;
				res.size   = rsize_q;
				res.last   = 1'b1;
				res.count  = cnt4(count_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= rd_en;
			case (state_q)
				ST_IDLE: begin
					if (req.valid && (req.op == OP_PUT) && !full) begin
						count_q <= CW'(count_q + 1'b1);
					end
				end
				ST_SCAN: begin
					if (hit) begin
						count_q <= last_idx;
					end
				end
				ST_DRAIN: begin
					if (load_ok && drain_last) begin
						count_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_addr;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					ent_q     <= '{region: req.req_region, size: req.req_size};
					iss_q     <= '0;
					rfound_q  <= 1'b0;
					rregion_q <= '0;
					rsize_q   <= '0;
				end
			end
			ST_SCAN: begin
				if (rd_en) begin
					iss_q <= CW'(iss_q + 1'b1);
				end
				if (hit) begin
					rfound_q  <= 1'b1;
					rregion_q <= rd_data.region;
					hole_q    <= rd_idx_s1;
				end
			end
			ST_SHIFT: begin
				if (rd_en) begin
					iss_q <= CW'(iss_q + 1'b1);
				end
				// slot 0 leaves the store as the evicted entry
				if (rd_valid_s1 && (rd_idx_s1 == '0)) begin
					rfound_q  <= 1'b1;
					rregion_q <= rd_data.region;
					rsize_q   <= rd_data.size;
				end
			end
			ST_DRAIN: begin
				if (load_ok && !drain_last) begin
					iss_q <= CW'(iss_q + 1'b1);
				end
			end
			default: ;
		endcase
	end
endmodule

// File: hw/rtl/size_keyed_region_recycle_cache.sv
// take scans one entry per cycle and refills a hole with the last live entry;
// put writes the new entry, or when full shifts the store down through the single ram read port;
// drain gives one result per cycle while the result sink keeps up; one item in work at a time, the next
// is taken while the last result waits in the output register
// reset clears the control state and live count; the entry ram is not cleared
// depends on skrc_pkg, skrc_req_if, skrc_res_if, skrc_ram, skrc_ctrl
`timescale 1ns / 1ps

module size_keyed_region_recycle_cache #(
	parameter int CAPACITY = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	skrc_req_if.sink   req,
	skrc_res_if.source res
);
	import skrc_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	logic          rd_en, wr_en;
	logic [AW-1:0] rd_addr, wr_addr;
	entry_t        rd_data, wr_data;
	logic          load_ok, res_load;
	res_t          res_d;
	logic          ov_q;
	res_t          od_q;

	assign load_ok = !ov_q || res.ready;

	skrc_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	skrc_ctrl #(
		.CAPACITY (CAPACITY),
		.AW       (AW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.load_ok  (load_ok),
		.res_load (res_load),
		.res      (res_d),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data)
	);

	// output register parts the sequencer from the result sink
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (res_load) begin
			ov_q <= 1'b1;
		end else if (res.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			od_q <= res_d;
		end
	end

	assign res.valid       = ov_q;
	assign res.found       = od_q.found;
	assign res.out_region  = od_q.region;
	assign res.out_size    = od_q.size;
	assign res.last        = od_q.last;
	assign res.count_after = od_q.count;

	a_load_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> (!ov_q || res.ready))
		else $error("result loaded into a full output register");

	a_no_accept_while_loading: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> !res_load)
		else $error("request taken while a result is being produced");

	a_no_ram_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && wr_en) |-> (rd_addr != wr_addr))
		else $error("ram read and write at the same entry");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q |-> ((CAPACITY > 15) || (od_q.count <= COUNT_OUT_W'(CAPACITY))))
		else $error("count after exceeds capacity");
endmodule

// File: test/size_keyed_region_recycle_cache_tb.sv
// self-checking testbench for size_keyed_region_recycle_cache: a directed table, then random
// traffic with random stalls on both channels, scored against a predictor of the region store
// depends on skrc_pkg, skrc_req_if, skrc_res_if and the cache rtl
`timescale 1ns / 1ps

module size_keyed_region_recycle_cache_tb;
	import skrc_pkg::*;

	localparam int SLOTS        = 8;
	localparam int RANDOM_ITEMS = 107;
	localparam int HOLD_CYCLES  = 150;
	localparam int STALL_LIMIT  = 5000;

	// op code the block leaves unused
	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

	typedef struct {
		logic [OP_W-1:0]     op;
		logic [REGION_W-1:0] region;
		logic [SIZE_W-1:0]   size;
		bit                  typed;
		res_t                want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	skrc_req_if req_bus ();
	skrc_res_if res_bus ();

	size_keyed_region_recycle_cache #(
		.CAPACITY(SLOTS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_bus),
		.res   (res_bus)
	);

	// shadow copy of the store
	logic [REGION_W-1:0] shadow_addr[SLOTS];
	logic [SIZE_W-1:0]   shadow_len[SLOTS];
	int                  shadow_live;

	res_t      expected_results[$];
	stim_row_t directed_rows[$];
	int        mismatch_count = 0;
	int        idle_cycles = 0;
	int        tx_burst;
	int        rx_burst = 0;
	bit        hold_pending;

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [47:0] rand48();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[47:0];
	endfunction

	// mostly short gaps, a few long ones, and now and then a run with none
	function automatic int pick_gap(inout int burst_left);
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			burst_left = $urandom_range(10, 30);
			return 0;
		end
		if (r < 45)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic void predict_cache(input logic [OP_W-1:0] op,
		input logic [REGION_W-1:0] region, input logic [SIZE_W-1:0] size,
		output res_t outs[$]);
		res_t r;
		int   hit;
		int   n;
		outs = {};
		r = '0;
		r.last = 1'b1;
		case (op)
			OP_TAKE: begin
				hit = -1;
				for (int i = 0; i < shadow_live; i++)
					if (hit < 0 && shadow_len[i] == size)
						hit = i;
				if (hit >= 0) begin
					r.found = 1'b1;
					r.region = shadow_addr[hit];
					shadow_live--;
					// last live entry fills the hole
					if (hit < shadow_live) begin
						shadow_addr[hit] = shadow_addr[shadow_live];
						shadow_len[hit] = shadow_len[shadow_live];
					end
				end
				r.count = shadow_live[3:0];
				outs.push_back(r);
			end
			OP_PUT: begin
				if (shadow_live == SLOTS) begin
					r.found = 1'b1;
					r.region = shadow_addr[0];
					r.size = shadow_len[0];
					for (int i = 1; i < SLOTS; i++) begin
						shadow_addr[i-1] = shadow_addr[i];
						shadow_len[i-1] = shadow_len[i];
					end
					shadow_live--;
				end
				shadow_addr[shadow_live] = region;
				shadow_len[shadow_live] = size;
				shadow_live++;
				r.count = shadow_live[3:0];
				outs.push_back(r);
			end
			OP_DRAIN: begin
				n = shadow_live;
				shadow_live = 0;
				if (n == 0)
					outs.push_back(r);
				for (int i = 0; i < n; i++) begin
					r.found = 1'b1;
					r.region = shadow_addr[i];
					r.size = shadow_len[i];
					r.last = (i == n - 1);
					r.count = '0;
					outs.push_back(r);
				end
			end
			default: begin
				r.count = shadow_live[3:0];
				outs.push_back(r);
			end
		endcase
	endfunction

	function automatic void add_row(logic [OP_W-1:0] op, logic [REGION_W-1:0] region,
		logic [SIZE_W-1:0] size, bit typed = 1'b0, logic found = 1'b0,
		logic [REGION_W-1:0] w_region = '0, logic [SIZE_W-1:0] w_size = '0,
		logic [COUNT_OUT_W-1:0] w_count = '0);
		stim_row_t row;
		row.op = op;
		row.region = region;
		row.size = size;
		row.typed = typed;
		row.want.found = found;
		row.want.region = w_region;
		row.want.size = w_size;
		row.want.last = 1'b1;
		row.want.count = w_count;
		directed_rows.push_back(row);
	endfunction

	task automatic report_mismatch(input string what, input logic [47:0] want,
		input logic [47:0] got);
		$display("%0t: mismatch on %s, expected %h got %h", $time, what, want, got);
		mismatch_count++;
	endtask

	task automatic offer_item(input logic [OP_W-1:0] op, input logic [REGION_W-1:0] region,
		input logic [SIZE_W-1:0] size, input bit typed, input res_t typed_res);
		int   gap;
		res_t outs[$];
		gap = pick_gap(tx_burst);
		if (gap > 0) begin
			req_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_bus.valid <= 1'b1;
		req_bus.op <= op;
		req_bus.req_region <= region;
		req_bus.req_size <= size;
		@(posedge clk);
		while (!req_bus.ready)
			@(posedge clk);
		predict_cache(op, region, size, outs);
		if (typed)
			expected_results.push_back(typed_res);
		else
			foreach (outs[i])
				expected_results.push_back(outs[i]);
		@(negedge clk);
	endtask

	// result scoreboard
	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result", '0, res_bus.out_region);
			end else begin
				want = expected_results.pop_front();
				if (res_bus.found !== want.found)
					report_mismatch("found", 48'(want.found), 48'(res_bus.found));
				if (res_bus.out_region !== want.region)
					report_mismatch("out_region", want.region, res_bus.out_region);
				if (res_bus.out_size !== want.size)
					report_mismatch("out_size", want.size, res_bus.out_size);
				if (res_bus.last !== want.last)
					report_mismatch("last", 48'(want.last), 48'(res_bus.last));
				if (res_bus.count_after !== want.count)
					report_mismatch("count_after", 48'(want.count),
						48'(res_bus.count_after));
			end
		end
	end

	// watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// result receiver with random back-pressure and one long hold-off
	initial begin
		int stall;
		bit hold_done;
		hold_done = 1'b0;
		res_bus.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_pending && !hold_done) begin
				hold_done = 1'b1;
				res_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				stall = pick_gap(rx_burst);
				if (stall > 0) begin
					res_bus.ready <= 1'b0;
					repeat (stall) @(negedge clk);
				end
			end
			res_bus.ready <= 1'b1;
			@(negedge clk);
		end
	end

	initial begin
		logic [SIZE_W-1:0]   size_pool[6];
		logic [REGION_W-1:0] region;
		logic [SIZE_W-1:0]   key;
		logic [OP_W-1:0]     op;
		res_t                none;
		int                  r;
		int                  put_pct;

		tx_burst = 0;
		hold_pending = 1'b0;
		shadow_live = 0;
		none = '0;
		foreach (shadow_addr[i]) begin
			shadow_addr[i] = '0;
			shadow_len[i] = '0;
		end

		arst_n <= 1'b0;
		req_bus.valid <= 1'b0;
		req_bus.op <= OP_TAKE;
		req_bus.req_region <= '0;
		req_bus.req_size <= '0;

		// empty store: miss, empty drain, spare op
		add_row(OP_TAKE, 48'h0, 48'h0, 1'b1, 1'b0, '0, '0, 4'd0);
		add_row(OP_DRAIN, 48'h0, 48'h0, 1'b1, 1'b0, '0, '0, 4'd0);
		add_row(OP_SPARE, '1, '1, 1'b1, 1'b0, '0, '0, 4'd0);
		// extremes, taken back out; a hit on address zero still reports found
		add_row(OP_PUT, 48'h0, 48'h0, 1'b1, 1'b0, '0, '0, 4'd1);
		add_row(OP_PUT, '1, '1, 1'b1, 1'b0, '0, '0, 4'd2);
		add_row(OP_TAKE, 48'h0, '1, 1'b1, 1'b1, '1, '0, 4'd1);
		add_row(OP_TAKE, '1, 48'h0, 1'b1, 1'b1, 48'h0, '0, 4'd0);
		// fill the store, duplicate sizes included
		add_row(OP_PUT, 48'h0, 48'd5, 1'b1, 1'b0, '0, '0, 4'd1);
		add_row(OP_PUT, 48'h1000, 48'd7, 1'b1, 1'b0, '0, '0, 4'd2);
		add_row(OP_PUT, 48'h2000, 48'd5, 1'b1, 1'b0, '0, '0, 4'd3);
		add_row(OP_PUT, 48'h3000, 48'd9, 1'b1, 1'b0, '0, '0, 4'd4);
		add_row(OP_PUT, 48'h4000, '1, 1'b1, 1'b0, '0, '0, 4'd5);
		add_row(OP_PUT, 48'h5000, 48'd0, 1'b1, 1'b0, '0, '0, 4'd6);
		add_row(OP_PUT, 48'h6000, 48'd7, 1'b1, 1'b0, '0, '0, 4'd7);
		add_row(OP_PUT, 48'h7000, 48'd3, 1'b1, 1'b0, '0, '0, 4'd8);
		// full: evicts the zero-address entry
		add_row(OP_PUT, 48'h8000, 48'd12);
		// lowest duplicate, last entry, middle entry, miss on a non-empty store
		add_row(OP_TAKE, 48'h0, 48'd7);
		add_row(OP_TAKE, 48'h0, 48'd3);
		add_row(OP_TAKE, 48'h0, 48'd9);
		add_row(OP_TAKE, 48'h0, 48'd1234);
		add_row(OP_SPARE, 48'h0, 48'd7);
		add_row(OP_DRAIN, 48'h0, 48'h0);
		add_row(OP_DRAIN, 48'h0, 48'h0, 1'b1, 1'b0, '0, '0, 4'd0);

		size_pool[0] = '0;
		size_pool[1] = '1;
		size_pool[2] = 48'd1;
		size_pool[3] = 48'd4096;
		size_pool[4] = rand48();
		size_pool[5] = rand48();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			offer_item(directed_rows[i].op, directed_rows[i].region, directed_rows[i].size,
				directed_rows[i].typed, directed_rows[i].want);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// receiver holds off while requests keep coming
			if (n == 12)
				hold_pending = 1'b1;
			// alternate fill-heavy and drain-heavy stretches
			put_pct = ((n / 40) % 2 == 0) ? 65 : 40;
			r = $urandom_range(0, 99);
			if (r < put_pct)
				op = OP_PUT;
			else if (r < put_pct + 25)
				op = OP_TAKE;
			else if (r < 96)
				op = OP_DRAIN;
			else
				op = OP_SPARE;
			key = ($urandom_range(0, 9) < 7) ? size_pool[$urandom_range(0, 5)] : rand48();
			r = $urandom_range(0, 9);
			region = (r == 0) ? '0 : (r == 1) ? '1 : rand48();
			offer_item(op, region, key, 1'b0, none);
		end
		req_bus.valid <= 1'b0;

		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SLOTS + 8) @(posedge clk);
		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
